// ===== rtl/vaq_pkg.sv =====
// types, widths and constants shared by the vertex attribute quantizer
// no dependencies; imported by vertex_attribute_quantizer
package vaq_pkg;

	// fixed-point format of components, minimums and step multiplier
	localparam int WORD_BITS     = 32;
	localparam int FRAC_BITS     = 16;

	// register port
	localparam int APB_DATA_BITS = 32;
	localparam int ADDR_BITS     = 5;
	localparam int REG_IDX_BITS  = ADDR_BITS - 2;
	localparam int DEPTH_BITS    = 5;

	// quantization depth limits
	localparam int MAX_DEPTH     = 16;
	localparam int MIN_DEPTH     = 7;
	localparam int RST_DEPTH     = 12;
	localparam int CODE_BITS     = MAX_DEPTH;

	// linear path: |comp - min| * step, rounded at 2*FRAC_BITS
	localparam int LIN_PROD_BITS = 2 * WORD_BITS;
	localparam int LIN_Q_BITS    = LIN_PROD_BITS + 1 - 2 * FRAC_BITS;

	// colour path: Q0.16 matrix, scaled by max code, divided by 255 * 2^(16+F)
	localparam int COEF_BITS     = 17;
	localparam int COEF_FRAC     = 16;
	localparam int ACC_BITS      = WORD_BITS + COEF_BITS;
	localparam int SCALED_BITS   = ACC_BITS + CODE_BITS + 1;
	localparam int BIASED_BITS   = SCALED_BITS + 1;
	localparam int COLOR_SHIFT   = COEF_FRAC + FRAC_BITS;
	localparam int QUO_BITS      = BIASED_BITS - COLOR_SHIFT;
	localparam int LIM_BITS      = CODE_BITS + 9;

	// divide by 255 through a reciprocal, exact for dividends below 255 * 2^16
	localparam int DIVIN_BITS    = CODE_BITS + 8;
	localparam int RECIP_BITS    = 25;
	localparam int RECIP_SHIFT   = 32;
	localparam logic [RECIP_BITS-1:0] RECIP_255 = 25'd16843010;

	typedef logic signed [COEF_BITS-1:0] coef_t;

	// rows: Y, U, V; columns: R, G, B
	localparam coef_t YUV_COEF [3][3] = '{
		'{ 17'sd13933,  17'sd46871,  17'sd4732},
		'{-17'sd7510,  -17'sd25258,  17'sd32768},
		'{ 17'sd32768, -17'sd29767, -17'sd3001}
	};

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_MIN_FIRST  = 3'd0,
		REG_MIN_SECOND = 3'd1,
		REG_MIN_THIRD  = 3'd2,
		REG_STEP       = 3'd3,
		REG_DEPTH      = 3'd4,
		REG_YUV        = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] comp_a;
		logic signed [WORD_BITS-1:0] comp_b;
		logic signed [WORD_BITS-1:0] comp_c;
	} attr_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] code_a;
		logic signed [WORD_BITS-1:0] code_b;
		logic signed [WORD_BITS-1:0] code_c;
		logic                        clipped;
	} quant_t;

endpackage

// ===== rtl/vertex_attribute_quantizer.sv =====
// vertex attribute quantizer: five-stage pipeline, linear and rgb-to-yuv paths
// depends on vaq_pkg
//
// usage:
//   attr channel (attr_valid, attr_ready, attr_data) takes one vertex attribute
//   per request: three signed Q16.16 components. quant channel (quant_valid,
//   quant_ready, quant_data) returns three codes and a clip flag per request.
//   an APB-style port holds min_first..min_third, step_multiplier, bit_depth
//   and yuv_convert at byte addresses 0x00..0x14; write them only while no
//   request is in flight.
// timing:
//   one request per cycle is sustained while quant_ready is high: every stage
//   advances whenever the one below it moves, and the five stages split the
//   multiplies, adds and compares.
// reset:
//   arst_n clears every stage valid and loads the register defaults (minimums
//   0, step 1.0, depth 12, colour path off). no clearing pass is needed.
// stall:
//   when quant_ready is low, the result holds in the output stage; empty
//   stages further up keep filling, so attr_ready drops only when all five
//   stages hold requests.
module vertex_attribute_quantizer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 attr_valid,
	output logic                                 attr_ready,
	input  vaq_pkg::attr_t                       attr_data,
	output logic                                 quant_valid,
	input  logic                                 quant_ready,
	output vaq_pkg::quant_t                      quant_data,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [vaq_pkg::ADDR_BITS-1:0]        paddr,
	input  logic [vaq_pkg::APB_DATA_BITS-1:0]    pwdata,
	output logic [vaq_pkg::APB_DATA_BITS-1:0]    prdata,
	output logic                                 pready
);
	import vaq_pkg::*;

	// configuration
	logic signed [WORD_BITS-1:0] min_q [3];
	logic [WORD_BITS-1:0]        step_q;
	logic [DEPTH_BITS-1:0]       depth_q;
	logic                        yuv_q;
	logic                        cfg_wr;
	logic [REG_IDX_BITS-1:0]     reg_sel;

	// derived from configuration
	logic [DEPTH_BITS-1:0]  dep;
	logic [CODE_BITS:0]     maxc_p1;
	logic [CODE_BITS-1:0]   maxc;
	logic [LIM_BITS-1:0]    lim;
	logic [BIASED_BITS-1:0] off_y;
	logic [BIASED_BITS-1:0] off_c;
	logic                   pass_mode;

	// handshake
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic yuv_s1, yuv_s2, yuv_s3, yuv_s4;
	logic pass_s1, pass_s2, pass_s3, pass_s4, pass_s5;

	// lane data
	logic signed [WORD_BITS-1:0] comp_in [3];
	logic signed [WORD_BITS-1:0] comp_s1 [3];
	logic signed [WORD_BITS-1:0] comp_s2 [3];
	logic signed [WORD_BITS-1:0] comp_s3 [3];
	logic signed [WORD_BITS-1:0] comp_s4 [3];

	logic signed [WORD_BITS:0]   diff [3];
	logic                        lin_neg_s1 [3];
	logic [WORD_BITS-1:0]        lin_mag_s1 [3];
	logic signed [ACC_BITS-1:0]  cprod [3][3];
	logic signed [ACC_BITS-1:0]  cprod_s1 [3][3];

	logic                        lin_neg_s2 [3];
	logic [LIN_PROD_BITS-1:0]    lin_prod_s2 [3];
	logic signed [ACC_BITS-1:0]  acc_s2 [3];

	logic [LIN_PROD_BITS:0]      lin_sum [3];
	logic                        lin_neg_s3 [3];
	logic                        lin_nclip_s3 [3];
	logic [LIN_Q_BITS-1:0]       lin_round_s3 [3];
	logic signed [SCALED_BITS-1:0] scaled_s3 [3];

	logic signed [BIASED_BITS-1:0] biased [3];
	logic [QUO_BITS-1:0]         quo [3];
	logic [CODE_BITS-1:0]        lin_code [3];
	logic                        lin_clip [3];
	logic [CODE_BITS-1:0]        lin_code_s4 [3];
	logic                        lin_clip_s4 [3];
	logic                        col_zero_s4 [3];
	logic                        col_sat_s4 [3];
	logic [DIVIN_BITS-1:0]       col_q_s4 [3];

	logic [DIVIN_BITS+RECIP_BITS-1:0] div_prod [3];
	logic [CODE_BITS-1:0]        code_nxt [3];
	logic                        clip_nxt [3];
	logic signed [WORD_BITS-1:0] out_nxt [3];
	quant_t                      quant_s5;

	// ---------------- register port ----------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_sel = paddr[ADDR_BITS-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q[0] <= '0;
			min_q[1] <= '0;
			min_q[2] <= '0;
			step_q   <= WORD_BITS'(1) << FRAC_BITS;
			depth_q  <= DEPTH_BITS'(RST_DEPTH);
			yuv_q    <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_MIN_FIRST:  min_q[0] <= WORD_BITS'(pwdata);
				REG_MIN_SECOND: min_q[1] <= WORD_BITS'(pwdata);
				REG_MIN_THIRD:  min_q[2] <= WORD_BITS'(pwdata);
				REG_STEP:       step_q   <= WORD_BITS'(pwdata);
				REG_DEPTH:      depth_q  <= pwdata[DEPTH_BITS-1:0];
				REG_YUV:        yuv_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_MIN_FIRST:  prdata = APB_DATA_BITS'(unsigned'(min_q[0]));
			REG_MIN_SECOND: prdata = APB_DATA_BITS'(unsigned'(min_q[1]));
			REG_MIN_THIRD:  prdata = APB_DATA_BITS'(unsigned'(min_q[2]));
			REG_STEP:       prdata = APB_DATA_BITS'(step_q);
			REG_DEPTH:      prdata = APB_DATA_BITS'(depth_q);
			REG_YUV:        prdata = APB_DATA_BITS'(yuv_q);
			default:        prdata = '0;
		endcase
	end

	// depths above the maximum act as the maximum
	assign dep       = (depth_q > DEPTH_BITS'(MAX_DEPTH)) ? DEPTH_BITS'(MAX_DEPTH) : depth_q;
	assign maxc_p1   = (CODE_BITS+1)'(1) << dep;
	assign maxc      = CODE_BITS'(maxc_p1 - 1'b1);
	// 255 * (maxc + 1): saturation limit on the pre-divide quotient
	assign lim       = (LIM_BITS'(maxc_p1) << 8) - LIM_BITS'(maxc_p1);
	assign off_y     = BIASED_BITS'(255) << (COLOR_SHIFT - 1);
	assign off_c     = BIASED_BITS'(lim) << (COLOR_SHIFT - 1);
	assign pass_mode = !yuv_q && (dep < DEPTH_BITS'(MIN_DEPTH));

	// ---------------- stage enables ----------------
	assign en_s5      = !v_s5 || quant_ready;
	assign en_s4      = !v_s4 || en_s5;
	assign en_s3      = !v_s3 || en_s4;
	assign en_s2      = !v_s2 || en_s3;
	assign en_s1      = !v_s1 || en_s2;
	assign attr_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= attr_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	assign comp_in[0] = attr_data.comp_a;
	assign comp_in[1] = attr_data.comp_b;
	assign comp_in[2] = attr_data.comp_c;

	// ---------------- stage 1: offset removal, matrix products ----------------
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = {comp_in[i][WORD_BITS-1], comp_in[i]} - {min_q[i][WORD_BITS-1], min_q[i]};
			for (int k = 0; k < 3; k++) begin
				cprod[i][k] = YUV_COEF[i][k] * comp_in[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			yuv_s1  <= yuv_q;
			pass_s1 <= pass_mode;
			for (int i = 0; i < 3; i++) begin
				comp_s1[i]    <= comp_in[i];
				lin_neg_s1[i] <= diff[i][WORD_BITS];
				lin_mag_s1[i] <= diff[i][WORD_BITS] ? WORD_BITS'(-diff[i]) : WORD_BITS'(diff[i]);
				for (int k = 0; k < 3; k++) begin
					cprod_s1[i][k] <= cprod[i][k];
				end
			end
		end
	end

	// ---------------- stage 2: step multiply, row sums ----------------
	always_ff @(posedge clk) begin
		if (en_s2) begin
			yuv_s2  <= yuv_s1;
			pass_s2 <= pass_s1;
			for (int i = 0; i < 3; i++) begin
				comp_s2[i]     <= comp_s1[i];
				lin_neg_s2[i]  <= lin_neg_s1[i];
				lin_prod_s2[i] <= lin_mag_s1[i] * step_q;
				acc_s2[i]      <= cprod_s1[i][0] + cprod_s1[i][1] + cprod_s1[i][2];
			end
		end
	end

	// ---------------- stage 3: rounding, scale by max code ----------------
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lin_sum[i] = {1'b0, lin_prod_s2[i]}
				+ ((LIN_PROD_BITS+1)'(1) << (2 * FRAC_BITS - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			yuv_s3  <= yuv_s2;
			pass_s3 <= pass_s2;
			for (int i = 0; i < 3; i++) begin
				comp_s3[i]      <= comp_s2[i];
				lin_neg_s3[i]   <= lin_neg_s2[i];
				// a negative offset clips unless it rounds up to zero
				lin_nclip_s3[i] <= lin_prod_s2[i]
					> (LIN_PROD_BITS'(1) << (2 * FRAC_BITS - 1));
				lin_round_s3[i] <= lin_sum[i][LIN_PROD_BITS:2*FRAC_BITS];
				scaled_s3[i]    <= acc_s2[i] * $signed({1'b0, maxc});
			end
		end
	end

	// ---------------- stage 4: clamping, rounding and chroma offsets ----------------
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			biased[i] = BIASED_BITS'(scaled_s3[i]) + ((i == 0) ? off_y : off_c);
			quo[i]    = biased[i][BIASED_BITS-1:COLOR_SHIFT];
			if (lin_neg_s3[i]) begin
				lin_code[i] = '0;
				lin_clip[i] = lin_nclip_s3[i];
			end else if (lin_round_s3[i] > LIN_Q_BITS'(maxc)) begin
				lin_code[i] = maxc;
				lin_clip[i] = 1'b1;
			end else begin
				lin_code[i] = lin_round_s3[i][CODE_BITS-1:0];
				lin_clip[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			yuv_s4  <= yuv_s3;
			pass_s4 <= pass_s3;
			for (int i = 0; i < 3; i++) begin
				comp_s4[i]     <= comp_s3[i];
				lin_code_s4[i] <= lin_code[i];
				lin_clip_s4[i] <= lin_clip[i];
				col_zero_s4[i] <= biased[i][BIASED_BITS-1];
				col_sat_s4[i]  <= !biased[i][BIASED_BITS-1] && (quo[i] >= QUO_BITS'(lim));
				col_q_s4[i]    <= quo[i][DIVIN_BITS-1:0];
			end
		end
	end

	// ---------------- stage 5: divide by 255, select, output register ----------------
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			div_prod[i] = col_q_s4[i] * RECIP_255;
			if (yuv_s4) begin
				if (col_zero_s4[i]) begin
					code_nxt[i] = '0;
				end else if (col_sat_s4[i]) begin
					code_nxt[i] = maxc;
				end else begin
					code_nxt[i] = div_prod[i][RECIP_SHIFT +: CODE_BITS];
				end
				clip_nxt[i] = col_zero_s4[i] || col_sat_s4[i];
			end else begin
				code_nxt[i] = lin_code_s4[i];
				clip_nxt[i] = lin_clip_s4[i];
			end
			out_nxt[i] = pass_s4 ? comp_s4[i] : signed'(WORD_BITS'(code_nxt[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			pass_s5          <= pass_s4;
			quant_s5.code_a  <= out_nxt[0];
			quant_s5.code_b  <= out_nxt[1];
			quant_s5.code_c  <= out_nxt[2];
			quant_s5.clipped <= !pass_s4 && (clip_nxt[0] || clip_nxt[1] || clip_nxt[2]);
		end
	end

	assign quant_valid = v_s5;
	assign quant_data  = quant_s5;

	// ---------------- assertions ----------------
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |->
			$countones({v_s1, v_s2, v_s3, v_s4, v_s5})
				== $past($countones({v_s1, v_s2, v_s3, v_s4, v_s5}))
				+ $past(attr_valid && attr_ready) - $past(quant_valid && quant_ready))
		else $error("pipeline occupancy does not match accepted and delivered requests");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		(quant_valid && !pass_s5) |->
			(quant_data.code_a[WORD_BITS-1:CODE_BITS] == '0)
			&& (quant_data.code_b[WORD_BITS-1:CODE_BITS] == '0)
			&& (quant_data.code_c[WORD_BITS-1:CODE_BITS] == '0))
		else $error("quantized code exceeds the maximum depth");

	a_pass_no_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(quant_valid && pass_s5) |-> !quant_data.clipped)
		else $error("clip flag set on a pass-through request");

endmodule
